// File: src/fathg_pkg.sv
// Shared types, constants and helper functions for the FLV audio tag header generator.
`timescale 1ns / 1ps

package fathg_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_CODEC = 2'd0;
    localparam logic [1:0] REG_RATE  = 2'd1;
    localparam logic [1:0] REG_CHAN  = 2'd2;

    localparam int LEN_W  = 13;
    localparam int SMP_W  = 13;
    localparam int RATE_W = 17;
    localparam int CHAN_W = 4;
    localparam int ST_W   = 48;
    localparam int TS_W   = 32;
    localparam int PTS_W  = 24;
    // sample_total * 1000 fits in 58 bits
    localparam int NUM_W  = ST_W + 10;
    localparam int CNT_W  = $clog2(NUM_W);
    localparam int IDX_W  = 5;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);
    localparam logic [CHAN_W-1:0] CHAN_RESET = CHAN_W'(2);

    // Byte positions inside one tag header
    localparam logic [IDX_W-1:0] IDX_FLAGS = IDX_W'(15);
    localparam logic [IDX_W-1:0] IDX_PKT   = IDX_W'(16);
    localparam logic [IDX_W-1:0] IDX_ASC0  = IDX_W'(17);
    localparam logic [IDX_W-1:0] IDX_ASC1  = IDX_W'(18);

    // Final byte position of each kind of tag
    localparam logic [IDX_W-1:0] LAST_MP3      = IDX_W'(15);
    localparam logic [IDX_W-1:0] LAST_AAC      = IDX_W'(16);
    localparam logic [IDX_W-1:0] LAST_CFG_BARE = IDX_W'(16);
    localparam logic [IDX_W-1:0] LAST_CFG_FULL = IDX_W'(18);

    localparam logic [7:0] TAG_TYPE_AUDIO = 8'h08;
    localparam logic [7:0] MP3_FLAGS_BASE = 8'h22;
    localparam logic [7:0] AAC_FLAGS      = 8'hAF;
    localparam logic [7:0] AAC_PKT_CFG    = 8'h00;
    localparam logic [7:0] AAC_PKT_RAW    = 8'h01;
    localparam logic [7:0] AAC_OBJ_LC     = 8'(2 << 3);

    // Command word from controller to datapath
    typedef struct packed {
        logic             accept;     // latch frame fields, advance sample total
        logic             emit;       // load one header byte into the output register
        logic             emit_cfg;   // byte belongs to the AAC config tag
        logic [IDX_W-1:0] emit_idx;   // byte position inside the tag
        logic             emit_last;  // final byte for this frame
        logic             tag_end;    // update previous tag size
        logic             ts_commit;  // take the new timestamp
    } t_cmd;

    // Status word from datapath to controller
    typedef struct packed {
        logic out_free;
        logic aac;
        logic rate_found;
        logic ts_busy;
    } t_sts;

    typedef struct packed {
        logic       found;
        logic [3:0] idx;
    } t_aac_rate;

    function automatic t_aac_rate aac_rate_lookup(input logic [RATE_W-1:0] rate);
        t_aac_rate r;
        r.found = 1'b1;
        unique case (rate)
            RATE_W'(96000): r.idx = 4'd0;
            RATE_W'(88200): r.idx = 4'd1;
            RATE_W'(64000): r.idx = 4'd2;
            RATE_W'(48000): r.idx = 4'd3;
            RATE_W'(44100): r.idx = 4'd4;
            RATE_W'(32000): r.idx = 4'd5;
            RATE_W'(24000): r.idx = 4'd6;
            RATE_W'(22050): r.idx = 4'd7;
            RATE_W'(16000): r.idx = 4'd8;
            RATE_W'(12000): r.idx = 4'd9;
            RATE_W'(11025): r.idx = 4'd10;
            RATE_W'(8000):  r.idx = 4'd11;
            RATE_W'(7350):  r.idx = 4'd12;
            default: begin
                r.found = 1'b0;
                r.idx   = 4'd0;
            end
        endcase
        return r;
    endfunction

    function automatic logic [1:0] mp3_rate_code(input logic [RATE_W-1:0] rate);
        logic [1:0] c;
        unique case (rate)
            RATE_W'(11025): c = 2'd1;
            RATE_W'(22050): c = 2'd2;
            default:        c = 2'd3;
        endcase
        return c;
    endfunction

endpackage

// File: src/fathg_tsdiv.sv
// Timestamp unit: sample total times 1000, then bit-serial division by the sample rate.
`timescale 1ns / 1ps

module fathg_tsdiv
    import fathg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ST_W-1:0]   i_total,
    input  logic [RATE_W-1:0] i_rate,
    output logic              o_busy,
    output logic [TS_W-1:0]   o_quot
);

    typedef enum logic [3:0] {
        P_IDLE = 4'b0001,
        P_MUL1 = 4'b0010,
        P_MUL2 = 4'b0100,
        P_DIV  = 4'b1000
    } t_phase;

    t_phase               r_phase, n_phase;
    logic [ST_W-1:0]      r_total;
    logic [ST_W+4:0]      r_p24;
    logic [NUM_W-1:0]     r_num;
    logic [RATE_W-1:0]    r_rem;
    logic [RATE_W-1:0]    r_div;
    logic [CNT_W-1:0]     r_cnt;
    logic [TS_W-1:0]      r_quot;

    logic [RATE_W:0]      rem_sh;
    logic                 q_bit;
    logic [RATE_W:0]      rem_sub;

    assign rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, r_div});
    assign rem_sub = rem_sh - {1'b0, r_div};

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            P_IDLE: if (i_start) n_phase = P_MUL1;
            P_MUL1: n_phase = P_MUL2;
            P_MUL2: n_phase = (r_div == '0) ? P_IDLE : P_DIV;
            P_DIV:  if (r_cnt == CNT_W'(NUM_W - 1)) n_phase = P_IDLE;
            default: n_phase = P_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_quot  <= '0;
        end else begin
            r_phase <= n_phase;
            if (r_phase == P_MUL2 && r_div == '0) begin
                r_quot <= '0;
            end else if (r_phase == P_DIV && r_cnt == CNT_W'(NUM_W - 1)) begin
                r_quot <= {r_num[TS_W-2:0], q_bit};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_phase)
            P_IDLE: begin
                if (i_start) begin
                    r_total <= i_total;
                    r_div   <= i_rate;
                end
            end
            P_MUL1: r_p24 <= {1'b0, r_total, 4'b0} + {2'b0, r_total, 3'b0};
            P_MUL2: begin
                // x*1000 = x*1024 - x*24
                r_num <= {r_total, 10'b0} - {5'b0, r_p24};
                r_rem <= '0;
                r_cnt <= '0;
            end
            P_DIV: begin
                r_rem <= q_bit ? rem_sub[RATE_W-1:0] : rem_sh[RATE_W-1:0];
                r_num <= {r_num[NUM_W-2:0], q_bit};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            default: ;
        endcase
    end

    assign o_busy = (r_phase != P_IDLE);
    assign o_quot = r_quot;

endmodule

// File: src/fathg_dp.sv
// Datapath: configuration registers, stream state, header byte selection and output register.
`timescale 1ns / 1ps

module fathg_dp
    import fathg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [RATE_W-1:0] i_cfg_data,
    input  logic [31:0]       i_s_tdata,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_m_tdata,
    output logic              o_m_tlast
);

    logic              r_codec;
    logic [RATE_W-1:0] r_rate;
    logic [CHAN_W-1:0] r_chan;
    logic [LEN_W-1:0]  r_len;
    logic [PTS_W-1:0]  r_prev;
    logic [ST_W-1:0]   r_total;
    logic [TS_W-1:0]   r_ts;
    logic              r_out_valid;
    logic [7:0]        r_out_data;
    logic              r_out_last;

    logic [ST_W-1:0]   total_next;
    logic              ts_busy;
    logic [TS_W-1:0]   ts_quot;
    t_aac_rate         aac_rate;
    logic [7:0]        mp3_flags;
    logic [PTS_W-1:0]  data_size;
    logic [LEN_W:0]    len_p1;
    logic [LEN_W:0]    len_p2;
    logic [LEN_W:0]    len_p12;
    logic [LEN_W:0]    len_p13;
    logic [7:0]        byte_sel;
    logic              out_free;

    assign total_next = r_total + ST_W'(i_s_tdata[LEN_W+SMP_W-1:LEN_W]);

    fathg_tsdiv u_tsdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.accept),
        .i_total (total_next),
        .i_rate  (r_rate),
        .o_busy  (ts_busy),
        .o_quot  (ts_quot)
    );

    assign aac_rate  = aac_rate_lookup(r_rate);
    assign mp3_flags = MP3_FLAGS_BASE | {4'b0, mp3_rate_code(r_rate), 2'b0}
                       | {7'b0, (r_chan == CHAN_W'(2))};
    assign len_p1  = {1'b0, r_len} + (LEN_W+1)'(1);
    assign len_p2  = {1'b0, r_len} + (LEN_W+1)'(2);
    assign len_p12 = {1'b0, r_len} + (LEN_W+1)'(12);
    assign len_p13 = {1'b0, r_len} + (LEN_W+1)'(13);

    always_comb begin
        if (i_cmd.emit_cfg) begin
            data_size = aac_rate.found ? PTS_W'(4) : PTS_W'(2);
        end else if (r_codec) begin
            data_size = PTS_W'(len_p2);
        end else begin
            data_size = PTS_W'(len_p1);
        end
    end

    always_comb begin
        case (i_cmd.emit_idx)
            IDX_W'(1):  byte_sel = r_prev[23:16];
            IDX_W'(2):  byte_sel = r_prev[15:8];
            IDX_W'(3):  byte_sel = r_prev[7:0];
            IDX_W'(4):  byte_sel = TAG_TYPE_AUDIO;
            IDX_W'(5):  byte_sel = data_size[23:16];
            IDX_W'(6):  byte_sel = data_size[15:8];
            IDX_W'(7):  byte_sel = data_size[7:0];
            IDX_W'(8):  byte_sel = r_ts[23:16];
            IDX_W'(9):  byte_sel = r_ts[15:8];
            IDX_W'(10): byte_sel = r_ts[7:0];
            IDX_W'(11): byte_sel = r_ts[31:24];
            IDX_FLAGS:  byte_sel = (r_codec || i_cmd.emit_cfg) ? AAC_FLAGS : mp3_flags;
            IDX_PKT:    byte_sel = i_cmd.emit_cfg ? AAC_PKT_CFG : AAC_PKT_RAW;
            IDX_ASC0:   byte_sel = AAC_OBJ_LC | {5'b0, aac_rate.idx[3:1]};
            IDX_ASC1:   byte_sel = {aac_rate.idx[0], r_chan, 3'b0};
            default:    byte_sel = 8'h00;
        endcase
    end

    assign out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codec     <= 1'b0;
            r_rate      <= RATE_RESET;
            r_chan      <= CHAN_RESET;
            r_prev      <= '0;
            r_total     <= '0;
            r_ts        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_CODEC: r_codec <= i_cfg_data[0];
                    REG_RATE:  r_rate  <= i_cfg_data;
                    REG_CHAN:  r_chan  <= i_cfg_data[CHAN_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                r_total <= total_next;
            end
            if (i_cmd.tag_end) begin
                if (i_cmd.emit_cfg) begin
                    r_prev <= aac_rate.found ? PTS_W'(15) : PTS_W'(13);
                end else begin
                    r_prev <= r_codec ? PTS_W'(len_p13) : PTS_W'(len_p12);
                end
            end
            if (i_cmd.ts_commit) begin
                r_ts <= ts_quot;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_len <= i_s_tdata[LEN_W-1:0];
        end
        if (i_cmd.emit) begin
            r_out_data <= byte_sel;
            r_out_last <= i_cmd.emit_last;
        end
    end

    assign o_sts.out_free   = out_free;
    assign o_sts.aac        = r_codec;
    assign o_sts.rate_found = aac_rate.found;
    assign o_sts.ts_busy    = ts_busy;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

// File: src/fathg_ctrl.sv
// Controller: frame acceptance, tag sequencing and byte position counter.
`timescale 1ns / 1ps

module fathg_ctrl
    import fathg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CFG  = 4'b0010,
        S_FRM  = 4'b0100,
        S_WAIT = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_cfg_sent, n_cfg_sent;
    logic [IDX_W-1:0] cfg_last;
    logic [IDX_W-1:0] frm_last;

    assign cfg_last = i_sts.rate_found ? LAST_CFG_FULL : LAST_CFG_BARE;
    assign frm_last = i_sts.aac ? LAST_AAC : LAST_MP3;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_cfg_sent = r_cfg_sent;
        o_cmd      = '0;
        o_cmd.emit_idx = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_idx        = '0;
                    n_state      = (i_sts.aac && !r_cfg_sent) ? S_CFG : S_FRM;
                end
            end
            S_CFG: begin
                o_cmd.emit_cfg = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_idx == cfg_last) begin
                        o_cmd.tag_end = 1'b1;
                        n_cfg_sent    = 1'b1;
                        n_idx         = '0;
                        n_state       = S_FRM;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_FRM: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_idx == frm_last) begin
                        o_cmd.tag_end   = 1'b1;
                        o_cmd.emit_last = 1'b1;
                        n_state         = S_WAIT;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_WAIT: begin
                if (!i_sts.ts_busy) begin
                    o_cmd.ts_commit = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_cfg_sent <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_cfg_sent <= n_cfg_sent;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("byte loaded into a full output register");

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_CFG || r_state == S_FRM))
        else $error("accepted frame did not start a tag");

    a_commit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ts_commit |-> !i_sts.ts_busy)
        else $error("timestamp taken while divider busy");

    a_cfg_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_cfg_sent) |-> $past(r_state == S_CFG))
        else $error("config flag set outside config tag");

endmodule

// File: src/flv_audio_tag_header_generator_core.sv
// Top level of the FLV audio tag header generator.
`timescale 1ns / 1ps

// Usage:
//   Input stream (i_s_*): one word per compressed audio frame, carrying its payload
//   length and sample count. Output stream (o_m_*): the FLV tag header bytes that
//   precede the frame, one byte per word, tlast on the final byte for the frame.
//   MP3 frames give 16 bytes; AAC frames give 17, and the first AAC frame after
//   reset is preceded by a 17- or 19-byte config tag.
//   Configuration channel (i_cfg_*): codec select, sample rate, channel count;
//   write only while no frame is in flight.
//   The first header byte is loaded into the output register from the config or frame
//   state that follows acceptance. A new frame is accepted only once the bit-serial
//   timestamp divider (2 multiply steps + 58 division steps) has finished, since the
//   next frame's timestamp must be known before its header starts.
//   A receiver stall holds the output register and pauses byte sequencing;
//   the divider keeps running, so stalls cost nothing as long as the header still
//   ends before the divider does (less room in the frame that brings the config tag).
//   Reset (synchronous, active low) restores the default configuration
//   (MP3, 44100 Hz, 2 channels), clears previous tag size, sample total,
//   timestamp and the config-sent flag, and empties the output register.

module flv_audio_tag_header_generator_core
    import fathg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Frame input words
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [31:0]       i_s_tdata,    // [12:0] frame_length, [25:13] frame_samples
    // Header byte output words
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_m_tdata,    // [7:0] header_byte
    output logic              o_m_tlast,    // last_byte
    // Configuration writes
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [RATE_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // Configuration writes are registered directly; always take them.
    assign o_cfg_ready = 1'b1;

    fathg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fathg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule
